// ===== src/lsxd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsxd_pkg
// Shared types, constants and helper functions of the low-res sprite XOR
// draw unit.
// ----------------------------------------------------------------------------
package lsxd_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int STRIP_W           = 32;
  localparam int SPRITE_W          = 8;
  localparam int WORD_W            = 16;
  localparam int POS_W             = 8;
  localparam int ROW_W             = 4;
  localparam int LINE_W            = 6;
  localparam int WSEL_W            = 3;
  localparam int TOP_W             = 8;
  localparam int MOD_W             = 14;
  localparam int WRAP_STEPS        = 5;

  typedef enum logic {
    FUNC_DRAW = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_BOT  = 4'b0100,
    S_PUT  = 4'b1000
  } state_e;

  // widen each sprite bit to two pixels
  function automatic logic [2*SPRITE_W-1:0] widen_byte(input logic [SPRITE_W-1:0] b);
    logic [2*SPRITE_W-1:0] w;
    w = '0;
    for (int i = 0; i < SPRITE_W; i++) begin
      w[2*i]   = b[i];
      w[2*i+1] = b[i];
    end
    return w;
  endfunction

  // reduce v modulo m by restoring compare-subtract steps; exact only for v < 32*m
  function automatic logic [MOD_W-1:0] wrap_pos(input logic [MOD_W-1:0] v,
                                                input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] r;
    logic [MOD_W-1:0] t;
    r = v;
    for (int i = WRAP_STEPS - 1; i >= 0; i--) begin
      t = m << i;
      if (r >= t) begin
        r = r - t;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/lowres_sprite_xor_draw_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lowres_sprite_xor_draw_unit
// Low-res sprite row XOR drawing into a one-bit line framebuffer.
//
// Requests enter on the in_valid_i/in_ready_o channel, one at a time; each
// request yields exactly one result on out_valid_o/out_ready_i. A draw
// request reads the top line of its row pair, writes the XORed line back and
// then copies the strip window into the line below, one memory port access
// per cycle. Reads, and draws without a line below (or off the bottom), go
// from S_LOOK to S_PUT; draws that copy pass through S_BOT between them.
// A new request is taken only once the previous one has done its read,
// write and copy passes and its result has been loaded from S_PUT.
// At reset the line valid bits clear, so the whole framebuffer reads as off
// at once; no clearing pass is needed. If the receiver stalls, the result is
// held in the output register and the finished next request waits until
// that register frees; the framebuffer update itself is never stalled.
// ----------------------------------------------------------------------------
module lowres_sprite_xor_draw_unit import lsxd_pkg::*; #(
  parameter int ScreenWidth  = SCREEN_WIDTH_DEF,
  parameter int ScreenHeight = SCREEN_HEIGHT_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              func_i,
  input  wire logic [POS_W-1:0]  pos_x_i,
  input  wire logic [POS_W-1:0]  pos_y_i,
  input  wire logic [ROW_W-1:0]  row_number_i,
  input  wire logic [SPRITE_W-1:0] sprite_byte_i,
  input  wire logic              last_row_i,
  input  wire logic [LINE_W-1:0] read_line_i,
  input  wire logic [WSEL_W-1:0] read_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   row_collision_o,
  output logic                   sprite_done_o,
  output logic [WORD_W-1:0]      pixels_read_o
);

  localparam int XW = $clog2(ScreenWidth);
  localparam int LW = $clog2(ScreenHeight);
  localparam int RW = ScreenWidth + 8 * WORD_W;
  localparam logic [MOD_W-1:0] WMod = MOD_W'(ScreenWidth);
  localparam logic [MOD_W-1:0] HMod = MOD_W'(ScreenHeight);
  localparam logic [TOP_W:0]   HTop = (TOP_W + 1)'(ScreenHeight);

  state_e state_q, state_d;

  logic              in_acc;
  logic [MOD_W-1:0]  x_wrap;
  logic [MOD_W-1:0]  y_wrap;
  logic [TOP_W:0]    top;
  logic              top_ok;
  logic              bot_ok;
  logic              rline_ok;
  logic [TOP_W:0]    rline_ext;
  logic              rd_en;
  logic [LW-1:0]     rd_addr;
  logic [ScreenWidth-1:0] rd_data;

  logic              func_q;
  logic [XW-1:0]     x_q;
  logic [SPRITE_W-1:0] sbyte_q;
  logic              last_q;
  logic [TOP_W:0]    top_q;
  logic              top_ok_q;
  logic              bot_ok_q;
  logic              rline_ok_q;
  logic [WSEL_W-1:0] rword_q;

  logic [ScreenWidth-1:0] set_mask;
  logic [ScreenWidth-1:0] copy_mask;
  logic [ScreenWidth-1:0] new_top;
  logic [ScreenWidth-1:0] new_top_q;
  logic [TOP_W:0]         bot;

  logic              wr_en;
  logic [LW-1:0]     wr_addr;
  logic [ScreenWidth-1:0] wr_data;
  logic [ScreenWidth-1:0] wr_mask;

  logic [RW-1:0]     rd_pad;
  logic [7:0]        wsel_base;
  logic [WORD_W-1:0] seg;
  logic [WORD_W-1:0] word;

  logic              res_coll_q;
  logic              res_done_q;
  logic [WORD_W-1:0] res_pix_q;

  logic              out_load;
  logic              out_valid_q;
  logic              out_coll_q;
  logic              out_done_q;
  logic [WORD_W-1:0] out_pix_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    x_wrap    = wrap_pos({{(MOD_W - POS_W - 1){1'b0}}, pos_x_i, 1'b0}, WMod);
    y_wrap    = wrap_pos({{(MOD_W - POS_W - 1){1'b0}}, pos_y_i, 1'b0}, HMod);
    top       = y_wrap[TOP_W:0] + {{(TOP_W - ROW_W){1'b0}}, row_number_i, 1'b0};
    top_ok    = top < HTop;
    bot_ok    = (top + 1'b1) < HTop;
    rline_ext = {{(TOP_W + 1 - LINE_W){1'b0}}, read_line_i};
    rline_ok  = rline_ext < HTop;
    rd_en     = in_acc && ((func_i == FUNC_READ) ? rline_ok : top_ok);
    rd_addr   = (func_i == FUNC_READ) ? rline_ext[LW-1:0] : top[LW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q     <= func_i;
      x_q        <= x_wrap[XW-1:0];
      sbyte_q    <= sprite_byte_i;
      last_q     <= last_row_i;
      top_q      <= top;
      top_ok_q   <= top_ok;
      bot_ok_q   <= bot_ok;
      rline_ok_q <= rline_ok;
      rword_q    <= read_word_i;
    end
  end

  lsxd_strip #(
    .ScreenWidth(ScreenWidth)
  ) u_strip (
    .x_i          (x_q),
    .sprite_byte_i(sbyte_q),
    .set_mask_o   (set_mask),
    .copy_mask_o  (copy_mask)
  );

  assign new_top = rd_data ^ set_mask;
  assign bot     = top_q + 1'b1;

  always_comb begin
    rd_pad    = {{(RW - ScreenWidth){1'b0}}, rd_data};
    wsel_base = {1'b0, rword_q, 4'b0000};
    seg       = rd_pad[wsel_base +: WORD_W];
    for (int k = 0; k < WORD_W; k++) begin
      word[WORD_W-1-k] = seg[k] & rline_ok_q;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = top_q[LW-1:0];
    wr_data = new_top;
    wr_mask = '1;
    if (state_q == S_LOOK && func_q == FUNC_DRAW && top_ok_q) begin
      wr_en = 1'b1;
    end else if (state_q == S_BOT) begin
      wr_en   = 1'b1;
      wr_addr = bot[LW-1:0];
      wr_data = new_top_q;
      wr_mask = copy_mask;
    end
  end

  lsxd_fb_mem #(
    .ScreenWidth (ScreenWidth),
    .ScreenHeight(ScreenHeight)
  ) u_fb_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .wr_mask_i(wr_mask)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOOK) begin
      new_top_q <= new_top;
      if (func_q == FUNC_READ) begin
        res_coll_q <= 1'b0;
        res_done_q <= 1'b0;
        res_pix_q  <= word;
      end else begin
        res_coll_q <= top_ok_q && (|(rd_data & set_mask));
        res_done_q <= last_q;
        res_pix_q  <= '0;
      end
    end
  end

  assign out_load = (state_q == S_PUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_LOOK;
      S_LOOK: begin
        if (func_q == FUNC_DRAW && top_ok_q && bot_ok_q) begin
          state_d = S_BOT;
        end else begin
          state_d = S_PUT;
        end
      end
      S_BOT:  state_d = S_PUT;
      S_PUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_coll_q <= res_coll_q;
      out_done_q <= res_done_q;
      out_pix_q  <= res_pix_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign row_collision_o = out_coll_q;
  assign sprite_done_o   = out_done_q;
  assign pixels_read_o   = out_pix_q;

endmodule
`default_nettype wire

// ===== src/lsxd_fb_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsxd_fb_mem
// Framebuffer line memory: one registered read port, one bit-masked write
// port, and a valid bit per line so unwritten lines read as all off.
// ----------------------------------------------------------------------------
module lsxd_fb_mem import lsxd_pkg::*; #(
  parameter int ScreenWidth  = SCREEN_WIDTH_DEF,
  parameter int ScreenHeight = SCREEN_HEIGHT_DEF,
  localparam int LW = $clog2(ScreenHeight)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   rd_en_i,
  input  wire logic [LW-1:0]          rd_addr_i,
  output logic      [ScreenWidth-1:0] rd_data_o,
  input  wire logic                   wr_en_i,
  input  wire logic [LW-1:0]          wr_addr_i,
  input  wire logic [ScreenWidth-1:0] wr_data_i,
  input  wire logic [ScreenWidth-1:0] wr_mask_i
);

  logic [ScreenWidth-1:0]  mem_q [ScreenHeight];
  logic [ScreenHeight-1:0] vld_q;
  logic [ScreenWidth-1:0]  rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // a first write to a line clears the bits outside the mask
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      for (int i = 0; i < ScreenWidth; i++) begin
        if (wr_mask_i[i] || !vld_q[wr_addr_i]) begin
          mem_q[wr_addr_i][i] <= wr_data_i[i] & wr_mask_i[i];
        end
      end
    end
    if (rd_en_i) begin
      rd_data_q <= vld_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ===== src/lsxd_strip.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsxd_strip
// Builds the line-wide XOR mask of one widened sprite row and the copy
// window of its 32-pixel strip, clipped at the right edge.
// ----------------------------------------------------------------------------
module lsxd_strip import lsxd_pkg::*; #(
  parameter int ScreenWidth = SCREEN_WIDTH_DEF,
  localparam int XW = $clog2(ScreenWidth)
) (
  input  wire logic [XW-1:0]          x_i,
  input  wire logic [SPRITE_W-1:0]    sprite_byte_i,
  output logic      [ScreenWidth-1:0] set_mask_o,
  output logic      [ScreenWidth-1:0] copy_mask_o
);

  localparam int PW = ScreenWidth + STRIP_W;

  logic [STRIP_W-1:0] strip;
  logic [STRIP_W-1:0] strip_rev;
  logic [4:0]         sh;
  logic [XW-1:0]      sx;
  logic [PW-1:0]      set_full;
  logic [PW-1:0]      copy_full;

  always_comb begin
    sh = 5'd16 - {1'b0, x_i[3:0]};
    strip = {{(STRIP_W - 2*SPRITE_W){1'b0}}, widen_byte(sprite_byte_i)} << sh;
    for (int i = 0; i < STRIP_W; i++) begin
      strip_rev[i] = strip[STRIP_W-1-i];
    end
    sx        = {x_i[XW-1:4], 4'b0000};
    set_full  = {{ScreenWidth{1'b0}}, strip_rev} << sx;
    copy_full = {{ScreenWidth{1'b0}}, {STRIP_W{1'b1}}} << sx;
  end

  assign set_mask_o  = set_full[ScreenWidth-1:0];
  assign copy_mask_o = copy_full[ScreenWidth-1:0];

endmodule
`default_nettype wire

// ===== bench/lowres_sprite_xor_draw_unit_tb.sv =====
// ----------------------------------------------------------------------------
// lowres_sprite_xor_draw_unit_tb
// Drives draw and read requests into the sprite XOR draw unit with random
// gaps on both channels and one long output hold-off. A shadow copy of the
// framebuffer predicts every result, and results are checked in order.
// ----------------------------------------------------------------------------
module lowres_sprite_xor_draw_unit_tb import lsxd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 400000;
  localparam int ChokeCycles = 400;
  localparam int DrainCycles = 20;

  typedef struct packed {
    func_e               func;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [ROW_W-1:0]    row;
    logic [SPRITE_W-1:0] sbyte;
    logic                last;
    logic [LINE_W-1:0]   rline;
    logic [WSEL_W-1:0]   rword;
  } req_t;

  typedef struct packed {
    logic              coll;
    logic              done;
    logic [WORD_W-1:0] pixels;
  } result_t;

  class frame_shadow;
    bit [SCREEN_WIDTH_DEF-1:0] fb [SCREEN_HEIGHT_DEF];
    result_t due_results[$];
    int errors;

    function new();
      foreach (fb[i]) fb[i] = '0;
      errors = 0;
    endfunction

    task report(string what, int got, int want);
      $display("ERROR at %0t: %s got %0h want %0h", $realtime, what, got, want);
      errors++;
    endtask

    function void apply_request(req_t r);
      result_t e;
      int x, y, sx, top, col;
      bit [15:0] wide;
      bit [31:0] strip;
      e = '0;
      if (r.func == FUNC_READ) begin
        for (int k = 0; k < WORD_W; k++) begin
          col = int'(r.rword) * WORD_W + k;
          if (int'(r.rline) < SCREEN_HEIGHT_DEF && col < SCREEN_WIDTH_DEF)
            e.pixels[WORD_W-1-k] = fb[r.rline][col];
        end
      end else begin
        x   = (int'(r.pos_x) * 2) % SCREEN_WIDTH_DEF;
        y   = (int'(r.pos_y) * 2) % SCREEN_HEIGHT_DEF;
        sx  = x & 'hF0;
        top = y + 2 * int'(r.row);
        if (top < SCREEN_HEIGHT_DEF) begin
          wide = '0;
          for (int i = 0; i < SPRITE_W; i++) begin
            wide[2*i]   = r.sbyte[i];
            wide[2*i+1] = r.sbyte[i];
          end
          strip = {16'h0000, wide} << (16 - (x & 'hF));
          for (int xl = 0; xl < STRIP_W; xl++) begin
            col = sx + xl;
            if (col < SCREEN_WIDTH_DEF) begin
              if (strip[STRIP_W-1-xl]) begin
                if (fb[top][col]) e.coll = 1'b1;
                fb[top][col] = ~fb[top][col];
              end
              if (top + 1 < SCREEN_HEIGHT_DEF) fb[top+1][col] = fb[top][col];
            end
          end
        end
        e.done = r.last;
      end
      due_results.push_back(e);
    endfunction

    task compare_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report("result with no request pending", got.pixels, 0);
      end else begin
        want = due_results.pop_front();
        if (got.coll !== want.coll) report("row_collision", got.coll, want.coll);
        if (got.done !== want.done) report("sprite_done", got.done, want.done);
        if (got.pixels !== want.pixels) report("pixels_read", got.pixels, want.pixels);
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                func_i;
  logic [POS_W-1:0]    pos_x_i;
  logic [POS_W-1:0]    pos_y_i;
  logic [ROW_W-1:0]    row_number_i;
  logic [SPRITE_W-1:0] sprite_byte_i;
  logic                last_row_i;
  logic [LINE_W-1:0]   read_line_i;
  logic [WSEL_W-1:0]   read_word_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                row_collision_o;
  logic                sprite_done_o;
  logic [WORD_W-1:0]   pixels_read_o;

  frame_shadow shadow;
  int  sent;
  int  cyc;
  int  hold_cnt;
  bit  tx_calm;
  bit  rx_calm;
  bit  choke_req;

  lowres_sprite_xor_draw_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .row_number_i    (row_number_i),
    .sprite_byte_i   (sprite_byte_i),
    .last_row_i      (last_row_i),
    .read_line_i     (read_line_i),
    .read_word_i     (read_word_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .row_collision_o (row_collision_o),
    .sprite_done_o   (sprite_done_o),
    .pixels_read_o   (pixels_read_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic req_t random_req();
    req_t r;
    r.func  = func_e'($urandom_range(0, 1));
    r.pos_x = POS_W'($urandom);
    r.pos_y = POS_W'($urandom);
    r.row   = ROW_W'($urandom);
    r.sbyte = SPRITE_W'($urandom);
    r.last  = 1'($urandom);
    r.rline = LINE_W'($urandom);
    r.rword = WSEL_W'($urandom);
    return r;
  endfunction

  function automatic req_t mk_draw(int x, int y, int row, int sbyte, bit last);
    req_t r;
    r       = random_req();
    r.func  = FUNC_DRAW;
    r.pos_x = POS_W'(x);
    r.pos_y = POS_W'(y);
    r.row   = ROW_W'(row);
    r.sbyte = SPRITE_W'(sbyte);
    r.last  = last;
    return r;
  endfunction

  function automatic req_t mk_read(int line, int word);
    req_t r;
    r       = random_req();
    r.func  = FUNC_READ;
    r.rline = LINE_W'(line);
    r.rword = WSEL_W'(word);
    return r;
  endfunction

  // enter at a falling edge, return at a falling edge after acceptance
  task automatic send_req(req_t r);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    func_i        <= r.func;
    pos_x_i       <= r.pos_x;
    pos_y_i       <= r.pos_y;
    row_number_i  <= r.row;
    sprite_byte_i <= r.sbyte;
    last_row_i    <= r.last;
    read_line_i   <= r.rline;
    read_word_i   <= r.rword;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.apply_request(r);
    sent++;
    @(negedge clk_i);
  endtask

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (choke_req) begin
        out_ready_i <= 1'b0;
        repeat (ChokeCycles) @(negedge clk_i);
        choke_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        out_ready_i <= 1'b0;
        hold_cnt--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      shadow.compare_result({row_collision_o, sprite_done_o, pixels_read_o});
      hold_cnt = rx_calm ? 0 : $urandom_range(0, 17);
    end
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int  sx, sy, rows, pick;
    bit  choked;
    shadow        = new();
    sent          = 0;
    cyc           = 0;
    hold_cnt      = 0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    choke_req     = 1'b0;
    choked        = 1'b0;
    sx            = 0;
    sy            = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = FUNC_DRAW;
    pos_x_i       = '0;
    pos_y_i       = '0;
    row_number_i  = '0;
    sprite_byte_i = '0;
    last_row_i    = 1'b0;
    read_line_i   = '0;
    read_word_i   = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_req(mk_read(0, 0));
    send_req(mk_read(63, 7));
    send_req(mk_draw(0, 0, 0, 'hFF, 0));
    send_req(mk_draw(0, 0, 0, 'hFF, 0));
    send_req(mk_draw(0, 0, 0, 'h80, 1));
    send_req(mk_read(0, 0));
    send_req(mk_read(1, 0));
    send_req(mk_draw(255, 255, 0, 'hFF, 1));
    send_req(mk_read(62, 7));
    send_req(mk_read(63, 7));
    send_req(mk_draw(63, 0, 15, 'h01, 0));
    send_req(mk_draw(0, 17, 15, 'hFF, 1));
    send_req(mk_read(30, 7));
    send_req(mk_draw(8, 20, 7, 'hAA, 0));
    send_req(mk_draw(8, 20, 7, 'h55, 0));
    send_req(mk_draw(8, 20, 7, 'hAA, 1));
    send_req(mk_read(54, 1));
    send_req(mk_read(55, 1));
    send_req(mk_draw(128, 32, 0, 'h00, 1));
    send_req(mk_draw(127, 31, 0, 'hC3, 0));
    send_req(mk_read(0, 0));
    send_req(mk_read(62, 7));

    while (sent < 775) begin
      if ($urandom_range(0, 7) == 0) tx_calm = ~tx_calm;
      if ($urandom_range(0, 7) == 0) rx_calm = ~rx_calm;
      if (!choked && sent >= 250) begin
        choke_req = 1'b1;
        tx_calm   = 1'b1;
        choked    = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        if ($urandom_range(0, 2) != 0) begin
          sx = $urandom_range(0, 255);
          sy = $urandom_range(0, 255);
        end
        rows = $urandom_range(1, 15);
        for (int r = 0; r < rows; r++)
          send_req(mk_draw(sx, sy, r, $urandom_range(0, 255), r == rows - 1));
      end else if (pick < 8) begin
        repeat ($urandom_range(1, 4))
          send_req(mk_read((2 * sy + $urandom_range(0, 31)) % 64,
                           (((2 * sx) % 128) / 16 + $urandom_range(0, 2)) % 8));
      end else begin
        send_req(random_req());
      end
    end
    in_valid_i <= 1'b0;

    while (shadow.due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (shadow.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
src/lsxd_pkg.sv
src/lsxd_fb_mem.sv
src/lsxd_strip.sv
src/lowres_sprite_xor_draw_unit.sv
bench/lowres_sprite_xor_draw_unit_tb.sv
